/* rtl/greedy_word_wrap_formatter_macros.svh */
// Assertion macros used by the checker file of the word wrap formatter.
`ifndef GREEDY_WORD_WRAP_FORMATTER_MACROS_SVH
`define GREEDY_WORD_WRAP_FORMATTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GWWF_ASSERT_NOW(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GWWF_ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/gwwf_pkg.sv */
`default_nettype none

package gwwf_pkg;

  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  localparam int         COL_W   = 7;
  localparam logic [6:0] COL_MAX = 7'd127;
  localparam int         WL_W    = 6;

  localparam int Q_DEPTH = 4;
  localparam int QP_W    = 2;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 7;

  localparam logic [CFG_AW-1:0] REG_FILL_ON        = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LEFT_MARGIN    = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LINE_WIDTH     = 2'd2;
  localparam logic [CFG_AW-1:0] REG_DOUBLE_SPACING = 2'd3;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_BYTE,
    POST_EOL,
    POST_BLANK
  } post_t;

  typedef struct packed {
    logic            place;
    logic [WL_W-1:0] len;
    logic            trunc;
    logic            bank;
    post_t           post;
    logic [7:0]      ch;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLACE,
    ST_NL1,
    ST_NL2,
    ST_PAD,
    ST_SEP,
    ST_WORD,
    ST_POST1,
    ST_POST2
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/greedy_word_wrap_formatter.sv */
// Greedy word wrap formatter.
// The slave stream takes one text byte per beat on s_tdata; s_tlast marks the
// end of a document, and the byte on that beat is ignored. The master stream
// gives the formatted text one byte per beat; m_tlast is set on the final
// byte caused by an input beat and m_tuser flags bytes of a word that was cut
// to WORD_MAX characters. Input beats that produce nothing (word characters
// in fill mode) give no output beat at all.
// Four registers are written through cfg_we, cfg_addr and cfg_data: fill
// enable, left margin, line width and double spacing, all zero after reset.
// The front end accepts a beat per cycle while its four-entry command queue
// has room and fewer than two finished words wait in the two-bank word store.
// The back end sends one byte per cycle while the receiver takes them, but none
// while it pops a command or makes the fit decision. A word after one space goes
// through pop, fit decision, space and its bytes; a passed-through byte goes
// through pop and the byte.
// When the receiver stalls, the output register holds its beat, the back end
// waits, and the queue then fills until s_tready drops.
// Reset empties the queue, sets the column to zero and the line-start flag;
// the word store is not cleared and needs no clearing pass.
`default_nettype none

module greedy_word_wrap_formatter #(
  parameter int WORD_MAX = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // [7:0] char_in
  input  wire logic                         s_tlast,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] char_out
  output logic                              m_tlast,
  output logic                              m_tuser,   // [0] word_truncated
  input  wire logic                         cfg_we,
  input  wire logic [gwwf_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [gwwf_pkg::CFG_DW-1:0]  cfg_data
);
  import gwwf_pkg::*;

  localparam int IDX_W = $clog2(WORD_MAX);
  localparam int DEPTH = 2 * (2 ** IDX_W);

  logic       fill_on;
  logic [3:0] left_margin;
  logic [6:0] line_width;
  logic       double_spacing;

  cmd_t       q_in;
  cmd_t       q_head;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       word_done;
  logic       ram_we;
  logic [IDX_W:0] ram_waddr;
  logic [IDX_W:0] ram_raddr;
  logic [7:0] ram_wdata;
  logic [7:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_on        <= 1'b0;
      left_margin    <= '0;
      line_width     <= '0;
      double_spacing <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FILL_ON:        fill_on        <= cfg_data[0];
        REG_LEFT_MARGIN:    left_margin    <= cfg_data[3:0];
        REG_LINE_WIDTH:     line_width     <= cfg_data[6:0];
        REG_DOUBLE_SPACING: double_spacing <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  gwwf_front #(
    .WORD_MAX(WORD_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fill_on   (fill_on),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in),
    .word_done (word_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  gwwf_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gwwf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gwwf_back #(
    .WORD_MAX(WORD_MAX)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .left_margin    (left_margin),
    .line_width     (line_width),
    .double_spacing (double_spacing),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .word_done      (word_done),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser)
  );

endmodule

`default_nettype wire

/* rtl/gwwf_ram.sv */
`default_nettype none

module gwwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/gwwf_cmd_fifo.sv */
`default_nettype none

module gwwf_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gwwf_pkg::cmd_t push_data,
  input  wire logic           pop,
  output gwwf_pkg::cmd_t      head,
  output logic                full,
  output logic                empty
);
  import gwwf_pkg::*;

  cmd_t            mem [Q_DEPTH];
  logic [QP_W-1:0] wptr;
  logic [QP_W-1:0] rptr;
  logic [QP_W:0]   count;

  assign head  = mem[rptr];
  assign full  = (count == (QP_W+1)'(Q_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gwwf_front.sv */
`default_nettype none

module gwwf_front #(
  parameter int WORD_MAX = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,
  input  wire logic                         s_tlast,
  input  wire logic                         fill_on,
  input  wire logic                         q_full,
  output logic                              q_push,
  output gwwf_pkg::cmd_t                    q_data,
  input  wire logic                         word_done,
  output logic                              ram_we,
  output logic [$clog2(WORD_MAX):0]         ram_waddr,
  output logic [7:0]                        ram_wdata
);
  import gwwf_pkg::*;

  localparam int IDX_W = $clog2(WORD_MAX);

  logic [WL_W-1:0] wl;
  logic [WL_W-1:0] wl_next;
  logic            ovf;
  logic            ovf_next;
  logic            als;
  logic            als_next;
  logic            wbank;
  logic            wbank_next;
  logic [1:0]      pend;
  logic [1:0]      pend_next;
  logic            acc;
  logic            push_word;

  always_comb begin
    s_tready   = !q_full && (pend != 2'd2);
    acc        = s_tvalid && s_tready;
    q_data.place = (wl != '0);
    q_data.len   = wl;
    q_data.trunc = ovf;
    q_data.bank  = wbank;
    q_data.post  = POST_NONE;
    q_data.ch    = s_tdata;
    q_push     = 1'b0;
    wl_next    = wl;
    ovf_next   = ovf;
    als_next   = als;
    ram_we     = 1'b0;
    ram_waddr  = {wbank, wl[IDX_W-1:0]};
    ram_wdata  = s_tdata;
    if (acc) begin
      if (s_tlast) begin
        q_data.post = fill_on ? POST_EOL : POST_NONE;
        q_push      = q_data.place || fill_on;
        wl_next     = '0;
        ovf_next    = 1'b0;
        als_next    = 1'b1;
      end else if (!fill_on) begin
        q_data.post = POST_BYTE;
        q_push      = 1'b1;
        wl_next     = '0;
        ovf_next    = 1'b0;
        als_next    = (s_tdata == CH_NEWLINE);
      end else if (s_tdata == CH_NEWLINE) begin
        if (als && wl == '0) begin
          q_data.post = POST_BLANK;
          q_push      = 1'b1;
        end else begin
          q_push = q_data.place;
        end
        wl_next  = '0;
        ovf_next = 1'b0;
        als_next = 1'b1;
      end else if (s_tdata == CH_SPACE) begin
        q_push   = q_data.place;
        wl_next  = '0;
        ovf_next = 1'b0;
        als_next = 1'b0;
      end else begin
        if (wl < WL_W'(WORD_MAX)) begin
          ram_we  = 1'b1;
          wl_next = wl + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
        als_next = 1'b0;
      end
    end
    push_word  = q_push && q_data.place;
    wbank_next = push_word ? ~wbank : wbank;
    case ({push_word, word_done})
      2'b10:   pend_next = pend + 2'd1;
      2'b01:   pend_next = pend - 2'd1;
      default: pend_next = pend;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wl    <= '0;
      ovf   <= 1'b0;
      als   <= 1'b1;
      wbank <= 1'b0;
      pend  <= '0;
    end else begin
      wl    <= wl_next;
      ovf   <= ovf_next;
      als   <= als_next;
      wbank <= wbank_next;
      pend  <= pend_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/gwwf_back.sv */
`default_nettype none

module gwwf_back #(
  parameter int WORD_MAX = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  wire gwwf_pkg::cmd_t          q_head,
  output logic                         q_pop,
  input  wire logic [3:0]              left_margin,
  input  wire logic [6:0]              line_width,
  input  wire logic                    double_spacing,
  output logic [$clog2(WORD_MAX):0]    ram_raddr,
  input  wire logic [7:0]              ram_rdata,
  output logic                         word_done,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [7:0]                   m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);
  import gwwf_pkg::*;

  localparam int IDX_W = $clog2(WORD_MAX);

  back_state_t     state;
  back_state_t     state_next;
  cmd_t            cmd;
  cmd_t            cmd_next;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic [3:0]      pad;
  logic [3:0]      pad_next;
  logic [WL_W-1:0] idx;
  logic [WL_W-1:0] idx_next;
  logic            slot;
  logic            emit;
  logic [7:0]      e_char;
  logic            e_last;
  logic            e_trunc;
  logic [7:0]      wrap_sum;
  logic [7:0]      end_sum;
  logic            last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    slot       = !m_tvalid || m_tready;
    state_next = state;
    cmd_next   = cmd;
    col_next   = col;
    pad_next   = pad;
    idx_next   = idx;
    q_pop      = 1'b0;
    word_done  = 1'b0;
    emit       = 1'b0;
    e_char     = CH_SPACE;
    e_last     = 1'b0;
    e_trunc    = 1'b0;
    wrap_sum   = {1'b0, col} + 8'd1 + {2'b00, cmd.len};
    end_sum    = {1'b0, col} + {2'b00, cmd.len};
    last_byte  = (idx == cmd.len - 1'b1);
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          cmd_next   = q_head;
          idx_next   = '0;
          state_next = q_head.place ? ST_PLACE : ST_POST1;
        end
      end
      ST_PLACE: begin
        if (col < {3'b000, left_margin}) begin
          pad_next   = left_margin - col[3:0];
          col_next   = {3'b000, left_margin};
          state_next = ST_PAD;
        end else if (col > {3'b000, left_margin}) begin
          if (wrap_sum > {1'b0, line_width}) begin
            pad_next   = left_margin;
            col_next   = {3'b000, left_margin};
            state_next = ST_NL1;
          end else begin
            col_next   = (col == COL_MAX) ? col : col + 1'b1;
            state_next = ST_SEP;
          end
        end else begin
          state_next = ST_WORD;
        end
      end
      ST_NL1: begin
        if (slot) begin
          emit   = 1'b1;
          e_char = CH_NEWLINE;
          if (double_spacing) begin
            state_next = ST_NL2;
          end else begin
            state_next = (pad != '0) ? ST_PAD : ST_WORD;
          end
        end
      end
      ST_NL2: begin
        if (slot) begin
          emit       = 1'b1;
          e_char     = CH_NEWLINE;
          state_next = (pad != '0) ? ST_PAD : ST_WORD;
        end
      end
      ST_PAD: begin
        if (slot) begin
          emit     = 1'b1;
          pad_next = pad - 1'b1;
          if (pad == 4'd1) begin
            state_next = ST_WORD;
          end
        end
      end
      ST_SEP: begin
        if (slot) begin
          emit       = 1'b1;
          state_next = ST_WORD;
        end
      end
      ST_WORD: begin
        if (slot) begin
          emit     = 1'b1;
          e_char   = ram_rdata;
          e_trunc  = cmd.trunc;
          e_last   = last_byte && (cmd.post == POST_NONE);
          idx_next = idx + 1'b1;
          if (last_byte) begin
            word_done  = 1'b1;
            col_next   = (end_sum > {1'b0, COL_MAX}) ? COL_MAX : end_sum[COL_W-1:0];
            state_next = (cmd.post == POST_NONE) ? ST_IDLE : ST_POST1;
          end
        end
      end
      ST_POST1: begin
        if (slot) begin
          case (cmd.post)
            POST_BYTE: begin
              emit       = 1'b1;
              e_char     = cmd.ch;
              e_last     = 1'b1;
              state_next = ST_IDLE;
            end
            POST_EOL: begin
              emit       = 1'b1;
              e_char     = CH_NEWLINE;
              e_last     = 1'b1;
              col_next   = '0;
              state_next = ST_IDLE;
            end
            POST_BLANK: begin
              emit       = 1'b1;
              e_char     = CH_NEWLINE;
              col_next   = '0;
              state_next = ST_POST2;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_POST2: begin
        if (slot) begin
          emit       = 1'b1;
          e_char     = CH_NEWLINE;
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ram_raddr = {cmd_next.bank, idx_next[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    pad <= pad_next;
    idx <= idx_next;
    if (emit) begin
      m_tdata <= e_char;
      m_tlast <= e_last;
      m_tuser <= e_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      col <= col_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gwwf_checker.sv */
`default_nettype none
`include "greedy_word_wrap_formatter_macros.svh"

module gwwf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);
  import gwwf_pkg::*;

  logic [9:0] out_beat;
  logic       sep_byte;

  assign out_beat = {m_tdata, m_tlast, m_tuser};
  assign sep_byte = (m_tdata == CH_SPACE) || (m_tdata == CH_NEWLINE);

  // No output beat is offered in the cycle after reset.
  `GWWF_ASSERT_NEXT(a_idle_after_reset, clk, 1'b0, rst, !m_tvalid)

  // A stalled output beat keeps its contents.
  `GWWF_ASSERT_NEXT(a_stall_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(out_beat))

  // Only word bytes carry the truncation flag, never separators.
  `GWWF_ASSERT_NOW(a_trunc_on_word, clk, rst, m_tvalid && m_tuser, !sep_byte)

endmodule

bind greedy_word_wrap_formatter gwwf_checker u_chk (.*);

`default_nettype wire
